/* hw/rtl/imm_pkg.sv */
// shared types and constants for the integer matrix multiply core
// no dependencies
package imm_pkg;

  localparam int MAX_DIM     = 8;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int DATA_W      = 32;
  localparam int DIM_W       = 4;
  localparam int IDX_W       = $clog2(MAX_DIM);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;

  typedef enum logic [1:0] {
    REG_A_ROWS = 2'd0,
    REG_A_COLS = 2'd1,
    REG_B_ROWS = 2'd2,
    REG_B_COLS = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    S_LOAD,
    S_MAC,
    S_DRAIN,
    S_ERR
  } state_t;

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/integer_matrix_multiply_core.sv */
// integer matrix multiply core: loads A then B, then streams C = A * B
// uses imm_pkg and two imm_ram instances for the operand stores
//
// usage:
//   input channel (in_valid/in_ready/element) takes A row-major, then B
//   row-major, one transfer per cycle while loading. sizes come from the
//   four config registers (a_rows, a_cols, b_rows, b_cols); the user must
//   write them only between runs, the core does not enforce it. after the
//   last element of B the core stops taking input and computes C with one
//   shared 32x32 multiplier, one term per cycle while issuing: read,
//   multiply, accumulate are three register stages. each C element is
//   formed by issuing its terms, draining the pipeline and loading the
//   output register in that order; a full 8x8 run loads 128 elements first.
//   results leave on out_valid/out_ready with out_row, out_col and last
//   set on the final element. mismatched inner sizes give one result with
//   size_error and last set and product zero.
//   a stalled receiver holds the result register and the sequencer waits;
//   after the last result the core takes input again even while that
//   result is still waiting.
//   reset (rst, synchronous) sets all sizes to 8 and restarts loading at A;
//   store contents are not cleared.
module integer_matrix_multiply_core import imm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [DIM_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] element,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] product,
  output logic [IDX_W-1:0]         out_row,
  output logic [IDX_W-1:0]         out_col,
  output logic                     last,
  output logic                     size_error
);

  state_t state, state_next;

  logic [DIM_W-1:0]  a_rows, a_cols, b_rows, b_cols;
  logic [DIM_W-1:0]  ar_eff, ac_eff, br_eff, bc_eff;
  logic [DIM_W-1:0]  run_ar, run_ac, run_bc;
  logic [CNT_W-1:0]  load_count, count_inc, a_size, b_size;
  logic              loading_b, a_done, b_done, in_xfer, final_b;
  logic [IDX_W-1:0]  i_idx, j_idx, k_idx;
  logic              i_last, j_last, k_last;
  logic [CNT_W-1:0]  a_lin, b_lin;
  logic [ADDR_W-1:0] a_raddr, b_raddr, waddr;
  logic              a_we, b_we;
  logic [DATA_W-1:0] a_rd, b_rd, prod, acc;
  logic              rd_valid, prod_valid, pipe_empty, out_free;
  logic              issue, emit, err_emit;

  assign ar_eff = eff_dim(a_rows);
  assign ac_eff = eff_dim(a_cols);
  assign br_eff = eff_dim(b_rows);
  assign bc_eff = eff_dim(b_cols);

  assign in_xfer   = in_valid && in_ready;
  assign count_inc = load_count + CNT_W'(1);
  assign a_size    = CNT_W'(ar_eff) * CNT_W'(ac_eff);
  assign b_size    = CNT_W'(br_eff) * CNT_W'(bc_eff);
  assign a_done    = count_inc >= a_size;
  assign b_done    = count_inc >= b_size;
  assign final_b   = in_xfer && loading_b && b_done;

  assign waddr = load_count[ADDR_W-1:0];
  assign a_we  = in_xfer && !loading_b && !load_count[CNT_W-1];
  assign b_we  = in_xfer && loading_b && !load_count[CNT_W-1];

  assign k_last = (DIM_W'(k_idx) + DIM_W'(1)) == run_ac;
  assign j_last = (DIM_W'(j_idx) + DIM_W'(1)) == run_bc;
  assign i_last = (DIM_W'(i_idx) + DIM_W'(1)) == run_ar;

  assign a_lin   = CNT_W'(i_idx) * CNT_W'(run_ac) + CNT_W'(k_idx);
  assign b_lin   = CNT_W'(k_idx) * CNT_W'(run_bc) + CNT_W'(j_idx);
  assign a_raddr = a_lin[ADDR_W-1:0];
  assign b_raddr = b_lin[ADDR_W-1:0];

  assign pipe_empty = !rd_valid && !prod_valid;
  assign out_free   = !out_valid || out_ready;

  imm_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_a_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (waddr),
    .wdata (element),
    .raddr (a_raddr),
    .rdata (a_rd)
  );

  imm_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_b_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (waddr),
    .wdata (element),
    .raddr (b_raddr),
    .rdata (b_rd)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_LOAD: begin
        if (final_b) begin
          state_next = (ac_eff != br_eff) ? S_ERR : S_MAC;
        end
      end
      S_MAC: begin
        if (k_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (pipe_empty && out_free) begin
          state_next = (i_last && j_last) ? S_LOAD : S_MAC;
        end
      end
      S_ERR: begin
        if (out_free) begin
          state_next = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    emit     = 1'b0;
    err_emit = 1'b0;
    case (state)
      S_LOAD:  in_ready = 1'b1;
      S_MAC:   issue    = 1'b1;
      S_DRAIN: emit     = pipe_empty && out_free;
      S_ERR:   err_emit = out_free;
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      a_rows     <= DIM_W'(MAX_DIM);
      a_cols     <= DIM_W'(MAX_DIM);
      b_rows     <= DIM_W'(MAX_DIM);
      b_cols     <= DIM_W'(MAX_DIM);
      load_count <= '0;
      loading_b  <= 1'b0;
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_A_ROWS: a_rows <= cfg_data;
          REG_A_COLS: a_cols <= cfg_data;
          REG_B_ROWS: b_rows <= cfg_data;
          REG_B_COLS: b_cols <= cfg_data;
          default:    a_rows <= a_rows;
        endcase
      end

      if (in_xfer) begin
        if ((!loading_b && a_done) || (loading_b && b_done)) begin
          loading_b  <= !loading_b;
          load_count <= '0;
        end else begin
          load_count <= count_inc;
        end
      end

      rd_valid   <= issue;
      prod_valid <= rd_valid;

      if (emit || err_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath and sequencer counters
  always_ff @(posedge clk) begin
    if (final_b) begin
      run_ar <= ar_eff;
      run_ac <= ac_eff;
      run_bc <= bc_eff;
      i_idx  <= '0;
      j_idx  <= '0;
      k_idx  <= '0;
      acc    <= '0;
    end else begin
      if (issue) begin
        k_idx <= k_last ? '0 : k_idx + IDX_W'(1);
      end
      if (prod_valid) begin
        acc <= acc + prod;
      end
      if (emit) begin
        acc <= '0;
        if (j_last) begin
          j_idx <= '0;
          i_idx <= i_idx + IDX_W'(1);
        end else begin
          j_idx <= j_idx + IDX_W'(1);
        end
      end
    end
    prod <= DATA_W'(a_rd * b_rd);
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      product    <= acc;
      out_row    <= i_idx;
      out_col    <= j_idx;
      last       <= i_last && j_last;
      size_error <= 1'b0;
    end else if (err_emit) begin
      product    <= '0;
      out_row    <= '0;
      out_col    <= '0;
      last       <= 1'b1;
      size_error <= 1'b1;
    end
  end

endmodule

/* hw/rtl/imm_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module imm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/imm_checker.sv */
// port-level checks for the integer matrix multiply core
// uses imm_pkg; bound to integer_matrix_multiply_core below
module imm_checker import imm_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] product,
  input logic [IDX_W-1:0]         out_row,
  input logic [IDX_W-1:0]         out_col,
  input logic                     last,
  input logic                     size_error
);

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(product) && $stable(out_row)
      && $stable(out_col) && $stable(last) && $stable(size_error))
    else $error("stalled result changed");

  // error result is a zero item that ends the run
  assert property (@(posedge clk) disable iff (rst)
    out_valid && size_error |-> last && product == '0 && out_row == '0 && out_col == '0)
    else $error("malformed error result");

  // core comes out of reset ready to load A
  assert property (@(posedge clk) $past(rst) && !rst |-> in_ready)
    else $error("not ready after reset");

  // results within a run walk row-major without gaps
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last ##1 out_valid [*1] |->
      (out_row == $past(out_row) && out_col == $past(out_col) + IDX_W'(1))
      || (out_row == $past(out_row) + IDX_W'(1) && out_col == '0)
      || !$past(out_valid && out_ready))
    else $error("result order broken");

endmodule

bind integer_matrix_multiply_core imm_checker u_imm_checker (.*);

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// testbench for integer_matrix_multiply_core: streams A and B at random sizes
// and checks every element of C against a matrix product computed here
// depends on imm_pkg and the core rtl
module tb_top;
  import imm_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int ITEM_TARGET = 220;

  typedef struct packed {
    logic [DATA_W-1:0] product;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic              last;
    logic              size_error;
  } c_entry_t;

  class gemm_checker;
    logic [DIM_W-1:0]  dims [4];
    logic [DATA_W-1:0] a_mem [STORE_DEPTH];
    logic [DATA_W-1:0] b_mem [STORE_DEPTH];
    int unsigned       fill_count;
    bit                filling_b;
    c_entry_t          expected_c [$];
    int                mismatches;

    function new();
      foreach (dims[r]) dims[r] = DIM_W'(MAX_DIM);
      fill_count = 0;
      filling_b  = 1'b0;
      mismatches = 0;
    endfunction

    function int unsigned clamp_dim(logic [DIM_W-1:0] v);
      if (v == '0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return 32'(v);
    endfunction

    function void set_dim(reg_index_t idx, logic [DIM_W-1:0] v);
      dims[idx] = v;
    endfunction

    function int pending_count();
      return expected_c.size();
    endfunction

    function void take_element(logic [DATA_W-1:0] v);
      int unsigned ar, ac, br, bc, i, j, k;
      logic [DATA_W-1:0] acc;
      c_entry_t c;
      ar = clamp_dim(dims[REG_A_ROWS]);
      ac = clamp_dim(dims[REG_A_COLS]);
      br = clamp_dim(dims[REG_B_ROWS]);
      bc = clamp_dim(dims[REG_B_COLS]);
      if (!filling_b) begin
        if (fill_count < STORE_DEPTH) a_mem[fill_count] = v;
        fill_count++;
        if (fill_count >= ar * ac) begin
          filling_b  = 1'b1;
          fill_count = 0;
        end
        return;
      end
      if (fill_count < STORE_DEPTH) b_mem[fill_count] = v;
      fill_count++;
      if (fill_count < br * bc) return;
      filling_b  = 1'b0;
      fill_count = 0;
      if (ac != br) begin
        c = '0;
        c.last = 1'b1;
        c.size_error = 1'b1;
        expected_c.push_back(c);
        return;
      end
      for (i = 0; i < ar; i++) begin
        for (j = 0; j < bc; j++) begin
          acc = '0;
          for (k = 0; k < ac; k++) acc = acc + a_mem[i * ac + k] * b_mem[k * bc + j];
          c.product    = acc;
          c.row        = IDX_W'(i);
          c.col        = IDX_W'(j);
          c.last       = (i + 1 == ar) && (j + 1 == bc);
          c.size_error = 1'b0;
          expected_c.push_back(c);
        end
      end
    endfunction

    function void check_product(logic [DATA_W-1:0] p, logic [IDX_W-1:0] row,
                                logic [IDX_W-1:0] col, logic lst, logic err);
      c_entry_t c;
      if (expected_c.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: product %0d row %0d col %0d last %0b err %0b",
                   $signed(p), row, col, lst, err);
        return;
      end
      c = expected_c.pop_front();
      if (c.product !== p || c.row !== row || c.col !== col || c.last !== lst ||
          c.size_error !== err) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %0d r%0d c%0d last %0b err %0b, got %0d r%0d c%0d last %0b err %0b",
                   $signed(c.product), c.row, c.col, c.last, c.size_error,
                   $signed(p), row, col, lst, err);
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [1:0]               cfg_index = REG_A_ROWS;
  logic [DIM_W-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] element = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] product;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic                     last;
  logic                     size_error;

  gemm_checker       sb;
  logic [DATA_W-1:0] preset [$];
  bit                tx_steady = 1'b0;
  bit                rx_steady = 1'b0;
  int                stall_left = 0;
  int                rx_pick = 0;
  int                idle_cycles = 0;
  int                items_sent = 0;

  integer_matrix_multiply_core uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .element    (element),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .product    (product),
    .out_row    (out_row),
    .out_col    (out_col),
    .last       (last),
    .size_error (size_error)
  );

  always #1 clk = ~clk;

  // result side: check each transfer, then pick the next ready level
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready)
        sb.check_product(product, out_row, out_col, last, size_error);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (rx_steady) begin
        out_ready <= 1'b1;
      end else begin
        rx_pick = $urandom_range(0, 99);
        if (rx_pick < 65) begin
          out_ready <= 1'b1;
        end else begin
          stall_left = (rx_pick < 93) ? $urandom_range(0, 2) : $urandom_range(8, 40);
          out_ready <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic logic [DATA_W-1:0] rand_element();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return '0;
      4, 5: return DATA_W'($urandom_range(0, 20) - 10);
      default: return $urandom;
    endcase
  endfunction

  function automatic int tx_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // mostly small sizes, sometimes large, zero or above the maximum
  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return DIM_W'($urandom_range(MAX_DIM + 1, 15));
      2: return DIM_W'($urandom_range(5, MAX_DIM));
      default: return DIM_W'($urandom_range(1, 3));
    endcase
  endfunction

  task automatic wait_idle();
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [DIM_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    sb.set_dim(idx, v);
  endtask

  task automatic send_element(input logic [DATA_W-1:0] v, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    element  <= v;
    do @(posedge clk); while (!in_ready);
    sb.take_element(v);
  endtask

  task automatic run_pair(input logic [DIM_W-1:0] ar, ac, br, bc);
    int unsigned total;
    logic [DATA_W-1:0] v;
    wait_idle();
    write_reg(REG_A_ROWS, ar);
    write_reg(REG_A_COLS, ac);
    write_reg(REG_B_ROWS, br);
    write_reg(REG_B_COLS, bc);
    cfg_we    <= 1'b0;
    tx_steady = ($urandom_range(0, 3) == 0);
    rx_steady = ($urandom_range(0, 3) == 0);
    total = sb.clamp_dim(ar) * sb.clamp_dim(ac) + sb.clamp_dim(br) * sb.clamp_dim(bc);
    for (int n = 0; n < total; n++) begin
      if (preset.size() > 0) v = preset.pop_front();
      else v = rand_element();
      send_element(v, tx_gap());
    end
    in_valid <= 1'b0;
    items_sent += total;
  endtask

  initial begin
    logic [DIM_W-1:0] ar, ac, br, bc;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // most negative squared wraps to zero
    preset = {32'h8000_0000, 32'h8000_0000};
    run_pair(1, 1, 1, 1);
    // largest values, sum wraps
    preset = {32'h7fff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 32'h0000_0001};
    run_pair(1, 2, 2, 1);
    // zero acts as one, above the maximum acts as the maximum
    preset = {32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
              32'h1234_5678, 32'hedcb_a988, 32'h0000_ffff, 32'hffff_ffff};
    run_pair(15, 0, 1, 0);
    // inner sizes differ
    run_pair(1, 2, 1, 1);

    run_pair(MAX_DIM, MAX_DIM, MAX_DIM, MAX_DIM);
    while (items_sent < ITEM_TARGET) begin
      ar = pick_dim();
      ac = pick_dim();
      bc = pick_dim();
      br = ($urandom_range(0, 5) == 0) ? pick_dim() : ac;
      run_pair(ar, ac, br, bc);
    end

    while (sb.pending_count() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/imm_pkg.sv
hw/rtl/imm_ram.sv
hw/rtl/integer_matrix_multiply_core.sv
hw/rtl/imm_checker.sv
bench/tb_top.sv
